FILE: src/indexed_array_list_defines.svh
// Assertion macros shared by the indexed array list RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef INDEXED_ARRAY_LIST_DEFINES_SVH
`define INDEXED_ARRAY_LIST_DEFINES_SVH

// Property checked on every edge outside reset.
`define IAL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define IAL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/ial_pkg.sv
// Shared types and constants for the indexed array list.
// No dependencies.
package ial_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int FUNC_W         = 3;
	localparam int STATUS_W       = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND   = 3'd0,
		FN_INSERT   = 3'd1,
		FN_DEL_LAST = 3'd2,
		FN_DEL_AT   = 3'd3,
		FN_GET      = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Broadcast to every cell; only set for a request that was accepted and passed its checks.
	typedef struct packed {
		logic append;
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

FILE: src/indexed_array_list.sv
// Latency: the result strobe (done) comes in the cycle after start is taken.
// Throughput: one request per cycle; busy is tied low and never holds a request back.
// A row of cells shifts the entries from the position upward together for insert and delete-at.
// Reset clears the entry count and the strobe; entry words are not reset.
// The receiver cannot stall: each result is presented for exactly one cycle.
// Depends on ial_pkg, ial_cell and indexed_array_list_defines.svh.
`include "indexed_array_list_defines.svh"

module indexed_array_list #(
	parameter int DEPTH      = ial_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = ial_pkg::WORD_WIDTH_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ial_pkg::FUNC_W-1:0]    func,
	input  logic [CNT_W-1:0]              position,
	input  logic [WORD_WIDTH-1:0]         value,
	output logic                          done,
	output logic [ial_pkg::STATUS_W-1:0]  status,
	output logic [WORD_WIDTH-1:0]         read_value,
	output logic [CNT_W-1:0]              count
);

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic                      acc;
	logic                      full;
	logic                      empty;
	logic                      inc;
	logic                      dec;
	logic                      rd_ok;
	ial_pkg::cell_ctrl_t       ctrl;
	ial_pkg::status_t          st_d;
	logic [WORD_WIDTH-1:0]     rd_or;
	logic [WORD_WIDTH-1:0]     words    [DEPTH];
	logic [WORD_WIDTH-1:0]     sel_words[DEPTH];

	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	ial_pkg::status_t          status_q;
	logic [WORD_WIDTH-1:0]     read_value_q;

	assign busy  = 1'b0;
	assign acc   = start && !busy;
	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);

	always_comb begin
		ctrl  = '0;
		st_d  = ial_pkg::ST_OK;
		inc   = 1'b0;
		dec   = 1'b0;
		rd_ok = 1'b0;
		case (func)
			ial_pkg::FN_APPEND: begin
				if (full) st_d = ial_pkg::ST_FULL;
				else begin
					ctrl.append = 1'b1;
					inc         = 1'b1;
				end
			end
			ial_pkg::FN_INSERT: begin
				// position is checked before fullness
				if (position > cnt_q) st_d = ial_pkg::ST_BAD_POS;
				else if (full) st_d = ial_pkg::ST_FULL;
				else begin
					ctrl.insert = 1'b1;
					inc         = 1'b1;
				end
			end
			ial_pkg::FN_DEL_LAST: begin
				if (empty) st_d = ial_pkg::ST_EMPTY;
				else dec = 1'b1;
			end
			ial_pkg::FN_DEL_AT: begin
				if (empty) st_d = ial_pkg::ST_EMPTY;
				else if (position >= cnt_q) st_d = ial_pkg::ST_BAD_POS;
				else begin
					ctrl.remove = 1'b1;
					dec         = 1'b1;
				end
			end
			ial_pkg::FN_GET: begin
				if (position >= cnt_q) st_d = ial_pkg::ST_BAD_POS;
				else rd_ok = 1'b1;
			end
			default: begin
				st_d = ial_pkg::ST_BAD_POS;
			end
		endcase
		if (!acc) begin
			ctrl = '0;
			inc  = 1'b0;
			dec  = 1'b0;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		// the top cell keeps its own word on a remove; it lies beyond the count anyway
		if (i == DEPTH - 1) begin : g_last
			assign right_w = words[i];
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		ial_cell #(
			.INDEX     (i),
			.CNT_W     (CNT_W),
			.WORD_WIDTH(WORD_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.pos     (position),
			.count   (cnt_q),
			.value   (value),
			.left    (left_w),
			.right   (right_w),
			.word    (words[i]),
			.sel_word(sel_words[i])
		);
	end

	// at most one cell matches the position, so an OR gathers the read
	always_comb begin
		rd_or = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rd_or = rd_or | sel_words[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= acc;
			if (inc) cnt_q <= cnt_q + 1'b1;
			else if (dec) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q     <= st_d;
			read_value_q <= rd_ok ? rd_or : '0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = cnt_q;

	`IAL_ASSERT(a_cnt_range, (cnt_q <= FULL_CNT), "entry count beyond capacity")
	`IAL_ASSERT_NEXT(a_done_follows, acc, done, "no result after a transfer")
	`IAL_ASSERT_NEXT(a_no_stray_done, !acc, !done, "result without a transfer")
	`IAL_ASSERT_NEXT(a_append_grows, acc && func == ial_pkg::FN_APPEND && !full, cnt_q == $past(cnt_q) + 1'b1 && status == ial_pkg::ST_OK, "append did not grow the list")
	`IAL_ASSERT(a_rd_zero, (done && status != ial_pkg::ST_OK) |-> (read_value == '0), "read word set on a rejected request")

endmodule

FILE: src/ial_cell.sv
// One storage cell of the list: holds a single entry and trades words with its neighbours.
// Depends on ial_pkg.
module ial_cell #(
	parameter int INDEX      = 0,
	parameter int CNT_W      = 7,
	parameter int WORD_WIDTH = ial_pkg::WORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  ial_pkg::cell_ctrl_t    ctrl,
	input  logic [CNT_W-1:0]       pos,
	input  logic [CNT_W-1:0]       count,
	input  logic [WORD_WIDTH-1:0]  value,
	input  logic [WORD_WIDTH-1:0]  left,
	input  logic [WORD_WIDTH-1:0]  right,
	output logic [WORD_WIDTH-1:0]  word,
	output logic [WORD_WIDTH-1:0]  sel_word
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [WORD_WIDTH-1:0] word_q;
	logic                  at_pos;

	assign at_pos   = (pos == IDX);
	assign word     = word_q;
	assign sel_word = at_pos ? word_q : '0;

	always_ff @(posedge clk) begin
		if ((ctrl.append && count == IDX) || (ctrl.insert && at_pos)) begin
			word_q <= value;
		end else if (ctrl.insert && IDX > pos) begin
			word_q <= left;
		end else if (ctrl.remove && IDX >= pos) begin
			word_q <= right;
		end
	end

endmodule

FILE: bench/ial_list_checker.sv
// Result checker for the indexed array list: keeps its own copy of the list,
// predicts the reply to each request taken and compares it with the reply strobed out.
// Depends on ial_pkg.
module ial_list_checker #(
	parameter int DEPTH      = ial_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = ial_pkg::WORD_WIDTH_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [ial_pkg::FUNC_W-1:0]    func,
	input  logic [CNT_W-1:0]              position,
	input  logic [WORD_WIDTH-1:0]         value,
	input  logic                          done,
	input  logic [ial_pkg::STATUS_W-1:0]  status,
	input  logic [WORD_WIDTH-1:0]         read_value,
	input  logic [CNT_W-1:0]              count,
	output int                            fail_count,
	output int                            replies_waiting,
	output int                            list_len
);
	import ial_pkg::*;

	typedef struct {
		status_t               st;
		logic [WORD_WIDTH-1:0] word;
		logic [CNT_W-1:0]      cnt;
	} list_reply_t;

	logic [WORD_WIDTH-1:0] words [DEPTH];
	int                    n_words;
	list_reply_t           replies_due [$];

	// Applies one request to the shadow list and returns the reply it should give.
	function automatic list_reply_t list_apply(input logic [FUNC_W-1:0] f, input int pos,
			input logic [WORD_WIDTH-1:0] val);
		list_reply_t r;
		r.st = ST_OK;
		r.word = '0;
		case (f)
			FN_APPEND: begin
				if (n_words >= DEPTH) r.st = ST_FULL;
				else begin
					words[n_words] = val;
					n_words++;
				end
			end
			FN_INSERT: begin
				// position is checked before fullness
				if (pos > n_words) r.st = ST_BAD_POS;
				else if (n_words >= DEPTH) r.st = ST_FULL;
				else begin
					for (int i = n_words; i > pos; i--) words[i] = words[i - 1];
					words[pos] = val;
					n_words++;
				end
			end
			FN_DEL_LAST: begin
				if (n_words == 0) r.st = ST_EMPTY;
				else n_words--;
			end
			FN_DEL_AT: begin
				if (n_words == 0) r.st = ST_EMPTY;
				else if (pos >= n_words) r.st = ST_BAD_POS;
				else begin
					for (int i = pos; i + 1 < n_words; i++) words[i] = words[i + 1];
					n_words--;
				end
			end
			FN_GET: begin
				if (pos >= n_words) r.st = ST_BAD_POS;
				else r.word = words[pos];
			end
			default: r.st = ST_BAD_POS;
		endcase
		r.cnt = CNT_W'(n_words);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_reply_t want;
		if (!arst_n) begin
			n_words = 0;
			replies_due.delete();
			fail_count = 0;
			replies_waiting <= 0;
			list_len <= 0;
		end else begin
			// a reply leaving at this edge belongs to an earlier transfer, so check first
			if (done) begin
				if (replies_due.size() == 0) begin
					fail_count++;
					$display("%0t: reply with none due: status %0d read %h count %0d",
						$time, status, read_value, count);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.st) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					end
					if (read_value !== want.word) begin
						fail_count++;
						$display("%0t: read_value expected %h actual %h", $time, want.word,
							read_value);
					end
					if (count !== want.cnt) begin
						fail_count++;
						$display("%0t: count expected %0d actual %0d", $time, want.cnt, count);
					end
				end
			end
			if (start && !busy) replies_due.push_back(list_apply(func, int'(position), value));
			replies_waiting <= replies_due.size();
			list_len <= n_words;
		end
	end

endmodule

FILE: bench/tb_indexed_array_list.sv
// Top of the indexed array list bench: clock, reset, request stimulus and verdict.
// Depends on ial_pkg, indexed_array_list and ial_list_checker.
module tb_indexed_array_list;
	import ial_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int WW          = WORD_WIDTH_DEF;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 150;

	// func codes the block does not define
	localparam logic [FUNC_W-1:0] FN_RSVD_LO  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_RSVD_MID = 3'd6;
	localparam logic [FUNC_W-1:0] FN_RSVD_HI  = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [FUNC_W-1:0]    func;
	logic [CNT_W-1:0]     position;
	logic [WW-1:0]        value;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [WW-1:0]        read_value;
	logic [CNT_W-1:0]     count;

	int fail_count;
	int replies_waiting;
	int list_len;
	int len_seen;
	int idle_pct;
	int quiet_cycles;
	bit fill_up;

	indexed_array_list i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	ial_list_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.position        (position),
		.value           (value),
		.done            (done),
		.status          (status),
		.read_value      (read_value),
		.count           (count),
		.fail_count      (fail_count),
		.replies_waiting (replies_waiting),
		.list_len        (list_len)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// list length as seen mid-cycle; only steers the stimulus, may lag one transfer
	always @(negedge clk) len_seen = list_len;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[indexed_array_list] ERROR");
			$finish;
		end else quiet_cycles <= quiet_cycles + 1;
	end

	// Holds start and the fields until the transfer is taken; busy is sampled mid-cycle.
	task automatic issue(input logic [FUNC_W-1:0] f, input int p, input logic [WW-1:0] v);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		position <= CNT_W'(p);
		value <= v;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (replies_waiting != 0);
		@(posedge clk);
	endtask

	function automatic logic [WW-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return WW'($urandom);
		endcase
	endfunction

	// Random walk that fills the list to the top and empties it again, with reads and noise.
	task automatic random_request();
		int len;
		int r;
		bit grow;
		len = len_seen;
		if (len >= DEPTH && $urandom_range(7) == 0) fill_up = 1'b0;
		else if (len == 0 && $urandom_range(3) == 0) fill_up = 1'b1;
		r = $urandom_range(99);
		grow = ($urandom_range(99) < 85) ? fill_up : !fill_up;
		if (r < 6) issue(FUNC_W'($urandom_range(7)), $urandom_range(DEPTH), pick_word());
		else if (r < 26) begin
			if ($urandom_range(9) == 0) issue(FN_GET, $urandom_range(DEPTH), '0);
			else issue(FN_GET, $urandom_range(len), '0);
		end else if (grow) begin
			if ($urandom_range(99) < 55) issue(FN_APPEND, $urandom_range(DEPTH), pick_word());
			else if ($urandom_range(9) == 0)
				issue(FN_INSERT, $urandom_range(DEPTH), pick_word());
			else issue(FN_INSERT, $urandom_range(len), pick_word());
		end else begin
			if ($urandom_range(99) < 40) issue(FN_DEL_LAST, $urandom_range(DEPTH), pick_word());
			else if (len == 0 || $urandom_range(9) == 0)
				issue(FN_DEL_AT, $urandom_range(DEPTH), pick_word());
			else issue(FN_DEL_AT, $urandom_range(len - 1), pick_word());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FN_APPEND;
		position <= '0;
		value <= '0;
		idle_pct = 16;
		fill_up = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		issue(FN_DEL_LAST, 0, '0);
		issue(FN_DEL_AT, 0, '0);
		issue(FN_DEL_AT, DEPTH, '1);
		issue(FN_GET, 0, '0);
		issue(FN_GET, DEPTH, '0);
		issue(FN_INSERT, 1, 32'h1234_5678);
		issue(FN_RSVD_LO, 0, '1);
		issue(FN_RSVD_MID, DEPTH - 1, '1);
		issue(FN_RSVD_HI, DEPTH, '1);
		// insert at the count appends
		issue(FN_INSERT, 0, '1);
		issue(FN_APPEND, 0, '0);
		issue(FN_INSERT, 2, 32'hA5A5_A5A5);
		issue(FN_INSERT, 1, 32'h5A5A_5A5A);
		issue(FN_INSERT, 5, 32'hDEAD_BEEF);
		issue(FN_GET, 0, '0);
		issue(FN_GET, 1, '0);
		issue(FN_GET, 3, '0);
		issue(FN_GET, 4, '0);
		issue(FN_DEL_AT, 1, '0);
		issue(FN_DEL_AT, 3, '0);
		issue(FN_GET, 1, '0);
		issue(FN_DEL_LAST, 0, '0);
		issue(FN_GET, 1, '0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 16 : (ph == 1) ? 88 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_request();
				if (n == PHASE_ITEMS / 2) drain();
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0 && replies_waiting == 0) $display("[indexed_array_list] OK");
		else $display("[indexed_array_list] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/ial_pkg.sv
src/ial_cell.sv
src/indexed_array_list.sv
bench/ial_list_checker.sv
bench/tb_indexed_array_list.sv
